/* rtl/cbrf_pkg.sv */
// Package with the shared types and constants of the cubic bisection root finder.
package cbrf_pkg;

   localparam int MAX_ITERATIONS = 1000;
   localparam int ITER_W = $clog2(MAX_ITERATIONS + 1);

   localparam int DATA_W = 32;
   localparam int X_W = 23;
   localparam int SQ_W = 29;
   localparam int OPA_W = 30;
   localparam int PROD_W = 53;
   localparam int LIN_W = 46;
   localparam int N_W = 60;
   localparam int MAG_W = 61;
   localparam int LIMIT_W = 51;

   localparam logic signed [DATA_W-1:0] CUBE_LIMIT = 32'sd4194304;
   localparam logic signed [LIN_W-1:0] LIN_OFFSET = 46'sd230 <<< 32;
   localparam logic [MAG_W-1:0] F_SAT_MAG = {1'b1, 60'b0};

   localparam logic [1:0] STATUS_OK = 2'd0;
   localparam logic [1:0] STATUS_INVALID = 2'd1;
   localparam logic [1:0] STATUS_LIMIT = 2'd2;

   typedef struct packed {
      logic signed [DATA_W-1:0] interval_low;
      logic signed [DATA_W-1:0] interval_high;
      logic signed [DATA_W-1:0] tolerance;
      logic signed [DATA_W-1:0] min_width;
   } cbrf_req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] root;
      logic [1:0]               status;
   } cbrf_rsp_type;

   typedef struct packed {
      logic                     start;
      logic signed [DATA_W-1:0] x;
   } cbrf_eval_req_type;

   typedef struct packed {
      logic             done;
      logic             neg;
      logic             zero;
      logic [MAG_W-1:0] mag;
   } cbrf_eval_rsp_type;

   typedef enum logic [1:0] {
      CT_IDLE,
      CT_EVAL_LO,
      CT_MID,
      CT_EVAL_MID
   } cbrf_ctl_state_type;

   typedef enum logic [1:0] {
      EV_IDLE,
      EV_SQUARE,
      EV_CUBE,
      EV_SUM
   } cbrf_ev_state_type;

endpackage

/* rtl/cbrf_eval.sv */
// Cubic evaluation unit: ten times f(x) in Q32.32 on one shared multiplier.
module cbrf_eval
   import cbrf_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  cbrf_eval_req_type eval_req,
   output cbrf_eval_rsp_type eval_rsp
);

   cbrf_ev_state_type state_ff, state_in;
   logic done_ff, done_in;

   logic signed [X_W-1:0]    x_ff, x_in;
   logic                     sat_ff, sat_in;
   logic                     sat_neg_ff, sat_neg_in;
   logic signed [PROD_W-1:0] mult_ff, mult_in;
   logic signed [LIN_W-1:0]  lin_ff, lin_in;
   logic                     neg_ff, neg_in;
   logic                     zero_ff, zero_in;
   logic [MAG_W-1:0]         mag_ff, mag_in;

   logic signed [OPA_W-1:0]  op_a;
   logic signed [PROD_W-1:0] product;
   logic signed [LIN_W-1:0]  x_ext;
   logic signed [N_W-1:0]    m32;
   logic signed [N_W-1:0]    lin_n;
   logic signed [N_W-1:0]    diff_a;
   logic signed [N_W-1:0]    diff_b;

   always_comb begin
      if (state_ff == EV_CUBE) begin
         op_a = $signed({1'b0, mult_ff[SQ_W+15:16]});
      end else begin
         op_a = {{(OPA_W-X_W){x_ff[X_W-1]}}, x_ff};
      end
      product = op_a * x_ff;
   end

   assign x_ext = {{(LIN_W-X_W){x_ff[X_W-1]}}, x_ff};
   assign m32 = {{(N_W-PROD_W-5){mult_ff[PROD_W-1]}}, mult_ff, 5'b0};
   assign lin_n = {{(N_W-LIN_W){lin_ff[LIN_W-1]}}, lin_ff};
   assign diff_a = m32 - lin_n;
   assign diff_b = lin_n - m32;

   always_comb begin
      state_in = state_ff;
      done_in = 1'b0;
      x_in = x_ff;
      sat_in = sat_ff;
      sat_neg_in = sat_neg_ff;
      mult_in = mult_ff;
      lin_in = lin_ff;
      neg_in = neg_ff;
      zero_in = zero_ff;
      mag_in = mag_ff;
      case (state_ff)
         EV_IDLE: begin
            if (eval_req.start) begin
               x_in = eval_req.x[X_W-1:0];
               sat_in = (eval_req.x >= CUBE_LIMIT) || (eval_req.x <= -CUBE_LIMIT);
               sat_neg_in = eval_req.x[DATA_W-1];
               state_in = EV_SQUARE;
            end
         end
         EV_SQUARE: begin
            mult_in = product;
            lin_in = (x_ext <<< 20) + (x_ext <<< 18) + (x_ext <<< 16) + LIN_OFFSET;
            state_in = EV_CUBE;
         end
         EV_CUBE: begin
            mult_in = product;
            state_in = EV_SUM;
         end
         EV_SUM: begin
            if (sat_ff) begin
               neg_in = sat_neg_ff;
               zero_in = 1'b0;
               mag_in = F_SAT_MAG;
            end else begin
               neg_in = m32 < lin_n;
               zero_in = m32 == lin_n;
               mag_in = (m32 < lin_n) ? {1'b0, diff_b} : {1'b0, diff_a};
            end
            done_in = 1'b1;
            state_in = EV_IDLE;
         end
         default: begin
            state_in = EV_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= EV_IDLE;
         done_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      sat_ff <= sat_in;
      sat_neg_ff <= sat_neg_in;
      mult_ff <= mult_in;
      lin_ff <= lin_in;
      neg_ff <= neg_in;
      zero_ff <= zero_in;
      mag_ff <= mag_in;
   end

   assign eval_rsp.done = done_ff;
   assign eval_rsp.neg = neg_ff;
   assign eval_rsp.zero = zero_ff;
   assign eval_rsp.mag = mag_ff;

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      eval_req.start |-> state_ff == EV_IDLE)
      else $error("Evaluation started while the unit was busy.");

   a_done_single: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff)
      else $error("Evaluation done held for more than one cycle.");

   a_zero_positive: assert property (@(posedge clock) disable iff (reset)
      done_ff && zero_ff |-> !neg_ff && mag_ff == '0)
      else $error("A zero function value carries a sign or magnitude.");

endmodule

/* rtl/cubic_bisection_root_finder.sv */
// Top level of the bisection root finder for the cubic 3.2x^3 - 2.1x - 23.
// A request with invalid arguments is answered in the cycle after it is accepted.
// Otherwise the result follows one evaluation of the low bound and k halvings
// (k from 1 to 1000): each halving is one evaluation on the shared multiplier.
// A valid request holds busy high until its result strobe, so one request is in flight.
// Synchronous reset returns the sequencer to idle and drops the result strobe.
module cubic_bisection_root_finder
   import cbrf_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  cbrf_req_type req_data,
   output logic         rsp_strobe,
   output cbrf_rsp_type rsp_data
);

   cbrf_ctl_state_type state_ff, state_in;
   logic [ITER_W-1:0] k_ff, k_in;
   logic              rsp_strobe_ff, rsp_strobe_in;

   logic signed [DATA_W-1:0] lo_ff, lo_in;
   logic signed [DATA_W-1:0] hi_ff, hi_in;
   logic signed [DATA_W-1:0] minw_ff, minw_in;
   logic [LIMIT_W-1:0]       limit_ff, limit_in;
   logic                     lo_neg_ff, lo_neg_in;
   logic                     lo_zero_ff, lo_zero_in;
   logic signed [DATA_W-1:0] mid_ff, mid_in;
   logic                     narrow_ff, narrow_in;
   cbrf_rsp_type             rsp_data_ff, rsp_data_in;

   cbrf_eval_req_type eval_req;
   cbrf_eval_rsp_type eval_rsp;

   logic signed [DATA_W:0] sum_lh;
   logic signed [DATA_W:0] diff_lh;
   logic [DATA_W+2:0]      tol10;
   logic                   args_valid;
   logic                   within_tol;
   logic                   same_sign;

   cbrf_eval u_eval (
      .clock    (clock),
      .reset    (reset),
      .eval_req (eval_req),
      .eval_rsp (eval_rsp)
   );

   assign sum_lh = {lo_ff[DATA_W-1], lo_ff} + {hi_ff[DATA_W-1], hi_ff};
   assign diff_lh = {hi_ff[DATA_W-1], hi_ff} - {lo_ff[DATA_W-1], lo_ff};
   assign tol10 = {req_data.tolerance, 3'b0} + {2'b0, req_data.tolerance, 1'b0};
   assign args_valid = !(req_data.interval_low > req_data.interval_high)
                       && (req_data.tolerance > 0)
                       && !req_data.min_width[DATA_W-1];
   assign within_tol = eval_rsp.mag <= {{(MAG_W-LIMIT_W){1'b0}}, limit_ff};
   assign same_sign = !lo_zero_ff && !eval_rsp.zero && (lo_neg_ff == eval_rsp.neg);

   always_comb begin
      state_in = state_ff;
      k_in = k_ff;
      rsp_strobe_in = 1'b0;
      lo_in = lo_ff;
      hi_in = hi_ff;
      minw_in = minw_ff;
      limit_in = limit_ff;
      lo_neg_in = lo_neg_ff;
      lo_zero_in = lo_zero_ff;
      mid_in = mid_ff;
      narrow_in = narrow_ff;
      rsp_data_in = rsp_data_ff;
      eval_req.start = 1'b0;
      eval_req.x = lo_ff;
      case (state_ff)
         CT_IDLE: begin
            if (start) begin
               lo_in = req_data.interval_low;
               hi_in = req_data.interval_high;
               minw_in = req_data.min_width;
               limit_in = {tol10, 16'b0};
               if (args_valid) begin
                  eval_req.start = 1'b1;
                  eval_req.x = req_data.interval_low;
                  k_in = ITER_W'(1);
                  state_in = CT_EVAL_LO;
               end else begin
                  rsp_strobe_in = 1'b1;
                  rsp_data_in.root = '0;
                  rsp_data_in.status = STATUS_INVALID;
               end
            end
         end
         CT_EVAL_LO: begin
            if (eval_rsp.done) begin
               lo_neg_in = eval_rsp.neg;
               lo_zero_in = eval_rsp.zero;
               state_in = CT_MID;
            end
         end
         CT_MID: begin
            mid_in = sum_lh[DATA_W:1];
            narrow_in = diff_lh < {minw_ff[DATA_W-1], minw_ff};
            eval_req.start = 1'b1;
            eval_req.x = sum_lh[DATA_W:1];
            state_in = CT_EVAL_MID;
         end
         CT_EVAL_MID: begin
            if (eval_rsp.done) begin
               if (within_tol || narrow_ff) begin
                  rsp_strobe_in = 1'b1;
                  rsp_data_in.root = mid_ff;
                  rsp_data_in.status = STATUS_OK;
                  state_in = CT_IDLE;
               end else if (k_ff == ITER_W'(MAX_ITERATIONS)) begin
                  rsp_strobe_in = 1'b1;
                  rsp_data_in.root = '0;
                  rsp_data_in.status = STATUS_LIMIT;
                  state_in = CT_IDLE;
               end else begin
                  if (same_sign) begin
                     lo_in = mid_ff;
                     lo_neg_in = eval_rsp.neg;
                     lo_zero_in = eval_rsp.zero;
                  end else begin
                     hi_in = mid_ff;
                  end
                  k_in = k_ff + ITER_W'(1);
                  state_in = CT_MID;
               end
            end
         end
         default: begin
            state_in = CT_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CT_IDLE;
         k_ff <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         k_ff <= k_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff <= lo_in;
      hi_ff <= hi_in;
      minw_ff <= minw_in;
      limit_ff <= limit_in;
      lo_neg_ff <= lo_neg_in;
      lo_zero_ff <= lo_zero_in;
      mid_ff <= mid_in;
      narrow_ff <= narrow_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign busy = state_ff != CT_IDLE;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data = rsp_data_ff;

   a_error_root_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.status != STATUS_OK |-> rsp_data.root == '0)
      else $error("An error result carries a nonzero root.");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> rsp_data.status == STATUS_OK || rsp_data.status == STATUS_INVALID
                     || rsp_data.status == STATUS_LIMIT)
      else $error("A result carries an undefined status code.");

   a_iter_range: assert property (@(posedge clock) disable iff (reset)
      busy |-> k_ff != '0 && k_ff <= ITER_W'(MAX_ITERATIONS))
      else $error("The halving count left its range.");

   a_valid_goes_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && args_valid |=> busy && !rsp_strobe)
      else $error("A valid request did not start a search.");

   a_done_while_waiting: assert property (@(posedge clock) disable iff (reset)
      eval_rsp.done |-> state_ff == CT_EVAL_LO || state_ff == CT_EVAL_MID)
      else $error("An evaluation finished while the sequencer was not waiting.");

endmodule
